// File: sv/cau_pkg.sv
// Shared types, constants and helper functions of the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_WIDTH      = 16;
    localparam int FRAC_BITS       = 12;
    localparam int CMD_WIDTH       = 3;

    // The angle, divide and root datapaths are sized for this data format.
    localparam int CORDIC_STEPS    = 31;
    localparam int ANGLE_FRAC      = 30;
    localparam int CORDIC_PRESHIFT = 28;
    localparam int DIV_STEPS       = DATA_WIDTH;
    localparam int SQRT_STEPS      = DATA_WIDTH;
    localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
    localparam int XY_WIDTH        = 48;
    localparam int Z_WIDTH         = 35;
    localparam int MAG_WIDTH       = 48;
    localparam int REM_WIDTH       = 48;
    localparam int SREM_WIDTH      = PROD_WIDTH + 2;

    localparam logic signed [Z_WIDTH-1:0] PI_Q30 = 35'sd3373259426;

    localparam logic [CMD_WIDTH-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_MUL   = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_DIV   = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_MAG   = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_ANGLE = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_MAG   = 3'd5,
        OP_ANGLE = 3'd6
    } t_op;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]         cmd;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         div_zero;
        logic                         saturated;
    } t_out_item;

    typedef struct packed {
        t_op                          op;
        logic signed [DATA_WIDTH-1:0] ar;
        logic signed [DATA_WIDTH-1:0] ai;
        logic signed [DATA_WIDTH-1:0] br;
        logic signed [DATA_WIDTH-1:0] bi;
    } t_cls;

    typedef struct packed {
        logic                  sat;
        logic [DATA_WIDTH-1:0] val;
    } t_clip;

    // Clip a sign/magnitude value into the signed data range.
    function automatic t_clip f_clip(input logic neg, input logic [MAG_WIDTH-1:0] mag);
        logic [MAG_WIDTH-1:0] lim;
        t_clip                r;
        lim   = (MAG_WIDTH'(1) << (DATA_WIDTH - 1)) - MAG_WIDTH'(!neg);
        r.sat = mag > lim;
        r.val = r.sat ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        if (neg) begin
            r.val = -r.val;
        end
        return r;
    endfunction

    // Round the magnitude to nearest (ties away from zero), drop sh bits, then clip.
    function automatic t_clip f_fix(input logic signed [MAG_WIDTH-1:0] v,
                                    input int unsigned sh);
        logic                 neg;
        logic [MAG_WIDTH-1:0] mag;
        neg = v[MAG_WIDTH-1];
        mag = neg ? MAG_WIDTH'(-v) : MAG_WIDTH'(v);
        if (sh != 0) begin
            mag = (mag + (MAG_WIDTH'(1) << (sh - 1))) >> sh;
        end
        return f_clip(neg, mag);
    endfunction

    // Arctangent of 2^-k, truncated to ANGLE_FRAC fraction bits.
    function automatic logic signed [Z_WIDTH-1:0] f_atan(input int k);
        logic signed [Z_WIDTH-1:0] r;
        case (k)
            0:       r = 35'sd843314856;
            1:       r = 35'sd497837829;
            2:       r = 35'sd263043836;
            3:       r = 35'sd133525158;
            4:       r = 35'sd67021686;
            5:       r = 35'sd33543515;
            6:       r = 35'sd16775850;
            7:       r = 35'sd8388437;
            8:       r = 35'sd4194282;
            9:       r = 35'sd2097149;
            10:      r = 35'sd1048575;
            default: r = (Z_WIDTH'(1) << (ANGLE_FRAC - k)) - Z_WIDTH'(1);
        endcase
        return r;
    endfunction

endpackage

// File: sv/cau_front.sv
// Front end: decodes the command of each accepted item and holds it in a two-entry queue.
`timescale 1ns / 1ps

module cau_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  cau_pkg::t_in_item i_item,
    output logic              o_vld,
    output cau_pkg::t_cls     o_cls,
    input  logic              i_take
);
    import cau_pkg::*;

    t_cls       c_cls;
    t_cls       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt,  n_cnt;
    logic       wr, rd;

    always_comb begin
        c_cls.ar = i_item.a_re;
        c_cls.ai = i_item.a_im;
        c_cls.br = i_item.b_re;
        c_cls.bi = i_item.b_im;
        case (i_item.cmd)
            CMD_ADD:   c_cls.op = OP_ADD;
            CMD_SUB:   c_cls.op = OP_SUB;
            CMD_MUL:   c_cls.op = OP_MUL;
            CMD_DIV:   c_cls.op = OP_DIV;
            CMD_MAG:   c_cls.op = OP_MAG;
            CMD_ANGLE: c_cls.op = OP_ANGLE;
            default:   c_cls.op = OP_NOP;
        endcase
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_cls  = r_mem[r_rptr];
    assign wr     = i_push & ~o_full;
    assign rd     = i_take & o_vld;

    always_comb begin
        n_wptr = wr ? ~r_wptr : r_wptr;
        n_rptr = rd ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= c_cls;
        end
    end

endmodule

// File: sv/cau_back.sv
// Back end: products, sums, then a shared row of stages for CORDIC, division and square root.
`timescale 1ns / 1ps

module cau_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  cau_pkg::t_cls      i_cls,
    output logic               o_take,
    input  logic               i_ready,
    output logic               o_vld,
    output cau_pkg::t_out_item o_res
);
    import cau_pkg::*;

    localparam int N = CORDIC_STEPS;
    localparam int W = DATA_WIDTH;

    logic adv;
    assign adv    = i_ready;
    assign o_take = adv & i_vld;

    // ---------------- stage A: products ----------------
    logic                          r_a_vld;
    t_op                           r_a_op;
    logic signed [PROD_WIDTH-1:0]  r_a_p_rr, r_a_p_ii, r_a_p_ri, r_a_p_ir, r_a_sq1, r_a_sq2;
    logic signed [W:0]             r_a_sum_re, r_a_sum_im;
    logic signed [XY_WIDTH-1:0]    r_a_cx, r_a_cy;
    logic signed [Z_WIDTH-1:0]     r_a_cz;
    logic                          r_a_azero;

    logic signed [W-1:0]           sq_x, sq_y;
    logic signed [XY_WIDTH-1:0]    c_x, c_y;

    assign sq_x = (i_cls.op == OP_MAG) ? i_cls.ar : i_cls.br;
    assign sq_y = (i_cls.op == OP_MAG) ? i_cls.ai : i_cls.bi;
    assign c_x  = XY_WIDTH'(i_cls.ar) <<< CORDIC_PRESHIFT;
    assign c_y  = XY_WIDTH'(i_cls.ai) <<< CORDIC_PRESHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_op   <= i_cls.op;
            r_a_p_rr <= i_cls.ar * i_cls.br;
            r_a_p_ii <= i_cls.ai * i_cls.bi;
            r_a_p_ri <= i_cls.ar * i_cls.bi;
            r_a_p_ir <= i_cls.ai * i_cls.br;
            r_a_sq1  <= sq_x * sq_x;
            r_a_sq2  <= sq_y * sq_y;
            if (i_cls.op == OP_SUB) begin
                r_a_sum_re <= (W+1)'(i_cls.ar) - (W+1)'(i_cls.br);
                r_a_sum_im <= (W+1)'(i_cls.ai) - (W+1)'(i_cls.bi);
            end else begin
                r_a_sum_re <= (W+1)'(i_cls.ar) + (W+1)'(i_cls.br);
                r_a_sum_im <= (W+1)'(i_cls.ai) + (W+1)'(i_cls.bi);
            end
            r_a_azero <= (i_cls.ar == '0) && (i_cls.ai == '0);
            // Left half plane: turn by pi first.
            if (i_cls.ar[W-1]) begin
                r_a_cx <= -c_x;
                r_a_cy <= -c_y;
                r_a_cz <= i_cls.ai[W-1] ? -PI_Q30 : PI_Q30;
            end else begin
                r_a_cx <= c_x;
                r_a_cy <= c_y;
                r_a_cz <= '0;
            end
        end
    end

    // ---------------- stage B: sums, simple results ----------------
    logic                          r_b_vld;
    t_op                           r_b_op;
    t_out_item                     r_b_res;
    logic                          r_b_nneg [2];
    logic [PROD_WIDTH-1:0]         r_b_nmag [2];
    logic [PROD_WIDTH-1:0]         r_b_d;
    logic signed [XY_WIDTH-1:0]    r_b_cx, r_b_cy;
    logic signed [Z_WIDTH-1:0]     r_b_cz;
    logic                          r_b_azero;

    logic signed [PROD_WIDTH:0]    v_mre, v_mim, v_nre, v_nim;
    logic [PROD_WIDTH:0]           a_nre, a_nim;
    t_clip                         c_re, c_im;
    t_out_item                     c_bres;

    always_comb begin
        v_mre = (PROD_WIDTH+1)'(r_a_p_rr) - (PROD_WIDTH+1)'(r_a_p_ii);
        v_mim = (PROD_WIDTH+1)'(r_a_p_ri) + (PROD_WIDTH+1)'(r_a_p_ir);
        v_nre = (PROD_WIDTH+1)'(r_a_p_rr) + (PROD_WIDTH+1)'(r_a_p_ii);
        v_nim = (PROD_WIDTH+1)'(r_a_p_ir) - (PROD_WIDTH+1)'(r_a_p_ri);
        a_nre = v_nre[PROD_WIDTH] ? (PROD_WIDTH+1)'(-v_nre) : (PROD_WIDTH+1)'(v_nre);
        a_nim = v_nim[PROD_WIDTH] ? (PROD_WIDTH+1)'(-v_nim) : (PROD_WIDTH+1)'(v_nim);
        c_re  = '0;
        c_im  = '0;
        case (r_a_op)
            OP_ADD, OP_SUB: begin
                c_re = f_fix(MAG_WIDTH'(r_a_sum_re), 0);
                c_im = f_fix(MAG_WIDTH'(r_a_sum_im), 0);
            end
            OP_MUL: begin
                c_re = f_fix(MAG_WIDTH'(v_mre), FRAC_BITS);
                c_im = f_fix(MAG_WIDTH'(v_mim), FRAC_BITS);
            end
            default: begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        c_bres.res_re    = c_re.val;
        c_bres.res_im    = c_im.val;
        c_bres.div_zero  = 1'b0;
        c_bres.saturated = c_re.sat | c_im.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_op      <= r_a_op;
            r_b_res     <= c_bres;
            r_b_nneg[0] <= v_nre[PROD_WIDTH];
            r_b_nneg[1] <= v_nim[PROD_WIDTH];
            r_b_nmag[0] <= a_nre[PROD_WIDTH-1:0];
            r_b_nmag[1] <= a_nim[PROD_WIDTH-1:0];
            r_b_d       <= $unsigned(r_a_sq1) + $unsigned(r_a_sq2);
            r_b_cx      <= r_a_cx;
            r_b_cy      <= r_a_cy;
            r_b_cz      <= r_a_cz;
            r_b_azero   <= r_a_azero;
        end
    end

    // ---------------- iteration stages ----------------
    logic                          r_i_vld   [N];
    t_op                           r_i_op    [N];
    t_out_item                     r_i_res   [N];
    logic signed [XY_WIDTH-1:0]    r_i_cx    [N];
    logic signed [XY_WIDTH-1:0]    r_i_cy    [N];
    logic signed [Z_WIDTH-1:0]     r_i_cz    [N];
    logic                          r_i_azero [N];
    logic [PROD_WIDTH-1:0]         r_i_d     [N];
    logic                          r_i_ovr   [N][2];
    logic                          r_i_neg   [N][2];
    logic [REM_WIDTH-1:0]          r_i_rem   [N][2];
    logic [W-1:0]                  r_i_q     [N][2];
    logic [SREM_WIDTH-1:0]         r_i_sr    [N];
    logic [W-1:0]                  r_i_rt    [N];

    logic                          s_vld   [N];
    t_op                           s_op    [N];
    t_out_item                     s_res   [N];
    logic signed [XY_WIDTH-1:0]    s_cx    [N];
    logic signed [XY_WIDTH-1:0]    s_cy    [N];
    logic signed [Z_WIDTH-1:0]     s_cz    [N];
    logic                          s_azero [N];
    logic [PROD_WIDTH-1:0]         s_d     [N];
    logic                          s_ovr   [N][2];
    logic                          s_neg   [N][2];
    logic [REM_WIDTH-1:0]          s_rem   [N][2];
    logic [W-1:0]                  s_q     [N][2];
    logic [SREM_WIDTH-1:0]         s_sr    [N];
    logic [W-1:0]                  s_rt    [N];

    for (genvar k = 0; k < N; k++) begin : g_it
        localparam logic signed [Z_WIDTH-1:0] ATAN = f_atan(k);

        logic signed [XY_WIDTH-1:0] dx, dy, n_cx, n_cy;
        logic signed [Z_WIDTH-1:0]  n_cz;
        logic [REM_WIDTH-1:0]       n_rem [2];
        logic [W-1:0]               n_q   [2];
        logic [SREM_WIDTH-1:0]      n_sr;
        logic [W-1:0]               n_rt;

        if (k == 0) begin : g_src
            for (genvar j = 0; j < 2; j++) begin : g_j
                assign s_rem[k][j] = REM_WIDTH'({r_b_nmag[j], FRAC_BITS'(0)});
                assign s_q[k][j]   = '0;
                assign s_neg[k][j] = r_b_nneg[j];
                // Quotient of at least 2^W: clips for sure.
                assign s_ovr[k][j] = {4'b0, r_b_nmag[j]} >= {r_b_d, 4'b0};
            end
            assign s_vld[k]   = r_b_vld;
            assign s_op[k]    = r_b_op;
            assign s_res[k]   = r_b_res;
            assign s_cx[k]    = r_b_cx;
            assign s_cy[k]    = r_b_cy;
            assign s_cz[k]    = r_b_cz;
            assign s_azero[k] = r_b_azero;
            assign s_d[k]     = r_b_d;
            assign s_sr[k]    = SREM_WIDTH'(r_b_d);
            assign s_rt[k]    = '0;
        end else begin : g_src
            for (genvar j = 0; j < 2; j++) begin : g_j
                assign s_rem[k][j] = r_i_rem[k-1][j];
                assign s_q[k][j]   = r_i_q[k-1][j];
                assign s_neg[k][j] = r_i_neg[k-1][j];
                assign s_ovr[k][j] = r_i_ovr[k-1][j];
            end
            assign s_vld[k]   = r_i_vld[k-1];
            assign s_op[k]    = r_i_op[k-1];
            assign s_res[k]   = r_i_res[k-1];
            assign s_cx[k]    = r_i_cx[k-1];
            assign s_cy[k]    = r_i_cy[k-1];
            assign s_cz[k]    = r_i_cz[k-1];
            assign s_azero[k] = r_i_azero[k-1];
            assign s_d[k]     = r_i_d[k-1];
            assign s_sr[k]    = r_i_sr[k-1];
            assign s_rt[k]    = r_i_rt[k-1];
        end

        // One CORDIC rotation, driving y toward zero.
        always_comb begin
            dx = s_cy[k] >>> k;
            dy = s_cx[k] >>> k;
            if (!s_cy[k][XY_WIDTH-1]) begin
                n_cx = s_cx[k] + dx;
                n_cy = s_cy[k] - dy;
                n_cz = s_cz[k] + ATAN;
            end else begin
                n_cx = s_cx[k] - dx;
                n_cy = s_cy[k] + dy;
                n_cz = s_cz[k] - ATAN;
            end
        end

        if (k < DIV_STEPS) begin : g_dsq
            localparam int B = DIV_STEPS - 1 - k;
            logic [REM_WIDTH-1:0]  dsh;
            logic [SREM_WIDTH-1:0] trial;

            // One quotient bit per lane of the divider, one root bit of the square root.
            always_comb begin
                dsh = REM_WIDTH'(s_d[k]) << B;
                for (int j = 0; j < 2; j++) begin
                    n_rem[j] = s_rem[k][j];
                    n_q[j]   = s_q[k][j];
                    if (s_rem[k][j] >= dsh) begin
                        n_rem[j]  = s_rem[k][j] - dsh;
                        n_q[j][B] = 1'b1;
                    end
                end
                trial = (SREM_WIDTH'(s_rt[k]) << (B + 1)) + (SREM_WIDTH'(1) << (2 * B));
                n_sr  = s_sr[k];
                n_rt  = s_rt[k];
                if (s_sr[k] >= trial) begin
                    n_sr    = s_sr[k] - trial;
                    n_rt[B] = 1'b1;
                end
            end
        end else begin : g_dsq
            always_comb begin
                for (int j = 0; j < 2; j++) begin
                    n_rem[j] = s_rem[k][j];
                    n_q[j]   = s_q[k][j];
                end
                n_sr = s_sr[k];
                n_rt = s_rt[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_i_vld[k] <= 1'b0;
            end else if (adv) begin
                r_i_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_i_op[k]    <= s_op[k];
                r_i_res[k]   <= s_res[k];
                r_i_cx[k]    <= n_cx;
                r_i_cy[k]    <= n_cy;
                r_i_cz[k]    <= n_cz;
                r_i_azero[k] <= s_azero[k];
                r_i_d[k]     <= s_d[k];
                r_i_sr[k]    <= n_sr;
                r_i_rt[k]    <= n_rt;
                for (int j = 0; j < 2; j++) begin
                    r_i_ovr[k][j] <= s_ovr[k][j];
                    r_i_neg[k][j] <= s_neg[k][j];
                    r_i_rem[k][j] <= n_rem[j];
                    r_i_q[k][j]   <= n_q[j];
                end
            end
        end
    end

    // ---------------- final rounding and clipping ----------------
    t_clip          f_c [2];
    logic           f_rnd;
    logic [W:0]     f_qq;
    logic [W:0]     f_rt;
    logic [MAG_WIDTH-1:0] f_mag;

    always_comb begin
        o_res = r_i_res[N-1];
        f_rnd = 1'b0;
        f_qq  = '0;
        f_mag = '0;
        f_rt  = '0;
        for (int j = 0; j < 2; j++) begin
            f_c[j] = '0;
        end
        case (r_i_op[N-1])
            OP_DIV: begin
                if (r_i_d[N-1] == '0) begin
                    o_res          = '0;
                    o_res.div_zero = 1'b1;
                end else begin
                    for (int j = 0; j < 2; j++) begin
                        f_rnd = {r_i_rem[N-1][j], 1'b0} >= (REM_WIDTH+1)'(r_i_d[N-1]);
                        f_qq  = (W+1)'(r_i_q[N-1][j]) + (W+1)'(f_rnd);
                        f_mag = r_i_ovr[N-1][j] ? (MAG_WIDTH'(1) << W) : MAG_WIDTH'(f_qq);
                        f_c[j] = f_clip(r_i_neg[N-1][j], f_mag);
                    end
                    o_res.res_re    = f_c[0].val;
                    o_res.res_im    = f_c[1].val;
                    o_res.div_zero  = 1'b0;
                    o_res.saturated = f_c[0].sat | f_c[1].sat;
                end
            end
            OP_MAG: begin
                f_rt   = (W+1)'(r_i_rt[N-1])
                       + (W+1)'(r_i_sr[N-1] > SREM_WIDTH'(r_i_rt[N-1]));
                f_c[0] = f_clip(1'b0, MAG_WIDTH'(f_rt));
                o_res.res_re    = f_c[0].val;
                o_res.res_im    = '0;
                o_res.div_zero  = 1'b0;
                o_res.saturated = f_c[0].sat;
            end
            OP_ANGLE: begin
                if (!r_i_azero[N-1]) begin
                    f_c[0] = f_fix(MAG_WIDTH'(r_i_cz[N-1]), ANGLE_FRAC - FRAC_BITS);
                end
                o_res.res_re    = f_c[0].val;
                o_res.res_im    = '0;
                o_res.div_zero  = 1'b0;
                o_res.saturated = f_c[0].sat;
            end
            default: begin
                o_res = r_i_res[N-1];
            end
        endcase
    end

    assign o_vld = r_i_vld[N-1] & adv;

endmodule

// File: sv/cau_outq.sv
// Two-entry result queue between the back end and the result port.
`timescale 1ns / 1ps

module cau_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  cau_pkg::t_out_item i_data,
    output logic               o_ready,
    output logic               o_empty,
    input  logic               i_rd,
    output cau_pkg::t_out_item o_data
);
    import cau_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt,  n_cnt;
    logic       rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign rd      = i_rd & ~o_empty;

    always_comb begin
        n_wptr = i_wr ? ~r_wptr : r_wptr;
        n_rptr = rd ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(i_wr) - 2'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: sv/complex_arithmetic_unit.sv
// Throughput: one item per cycle while the result queue has room; the depth is set by the
// 31-stage CORDIC angle pipeline, with divide and square root taking one quotient or root
// bit per stage in the same row. Each side has a two-entry queue; a full result queue
// stalls the whole back end. Reset (synchronous, active low) empties both queues and the
// pipeline valid bits.
`timescale 1ns / 1ps

module complex_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cau_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output cau_pkg::t_out_item o_result
);
    import cau_pkg::*;

    logic      w_cls_vld;
    t_cls      w_cls;
    logic      w_take;
    logic      w_ready;
    logic      w_res_vld;
    t_out_item w_res;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_vld   (w_cls_vld),
        .o_cls   (w_cls),
        .i_take  (w_take)
    );

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_cls_vld),
        .i_cls   (w_cls),
        .o_take  (w_take),
        .i_ready (w_ready),
        .o_vld   (w_res_vld),
        .o_res   (w_res)
    );

    cau_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_vld),
        .i_data  (w_res),
        .o_ready (w_ready),
        .o_empty (empty),
        .i_rd    (pop),
        .o_data  (o_result)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.div_zero |-> o_result.res_re == '0 && o_result.res_im == '0)
        else $error("divide by zero with nonzero result");

    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_result.div_zero && o_result.saturated))
        else $error("div_zero and saturated both set");

    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> w_ready)
        else $error("result written into full queue");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the complex arithmetic unit: directed, random and back-to-back items.
`timescale 1ns / 1ps

module tb_top;
    import cau_pkg::*;

    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_HI = 3'd7;
    localparam int  DRAIN_CYCLES = 60;
    localparam logic signed [15:0] MAX_POS = 16'sh7fff;
    localparam logic signed [15:0] MAX_NEG = -16'sh8000;

    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } t_signmag;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   i_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_result;

    t_out_item  pending_results[$];
    bit         failed = 1'b0;
    bit         idle_en = 1'b1;
    int         pop_stall = 0;

    complex_arithmetic_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_signmag sm_of(input longint v);
        t_signmag r;
        r.neg = v < 0;
        r.mag = v < 0 ? 64'(-v) : 64'(v);
        return r;
    endfunction

    function automatic t_signmag sm_mul(input longint x, input longint y);
        t_signmag r;
        r.mag = sm_of(x).mag * sm_of(y).mag;
        r.neg = (r.mag != 0) && ((x < 0) != (y < 0));
        return r;
    endfunction

    function automatic t_signmag sm_sum(input t_signmag s, input t_signmag t);
        t_signmag r;
        if (s.neg == t.neg) begin
            r.mag = s.mag + t.mag;
            r.neg = s.neg;
        end else if (s.mag >= t.mag) begin
            r.mag = s.mag - t.mag;
            r.neg = s.neg;
        end else begin
            r.mag = t.mag - s.mag;
            r.neg = t.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic t_signmag sm_flip(input t_signmag s);
        if (s.mag != 0) s.neg = !s.neg;
        return s;
    endfunction

    function automatic logic [63:0] round_drop(input logic [63:0] mag, input int sh);
        return (mag + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [15:0] clip_part(input t_signmag v, inout bit sat);
        logic [63:0] lim;
        lim = 64'd1 << 15;
        if (!v.neg) lim = lim - 1;
        if (v.mag > lim) begin
            v.mag = lim;
            sat = 1'b1;
        end
        return v.neg ? 16'(-v.mag) : 16'(v.mag);
    endfunction

    // Long division producing FRAC_BITS fraction bits, rounded half away from zero.
    function automatic t_signmag quotient(input t_signmag n, input logic [63:0] d);
        logic [63:0] q, r;
        bit over;
        q = n.mag / d;
        r = n.mag % d;
        over = q > (64'd1 << 40);
        for (int i = 0; i < FRAC_BITS && !over; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q + 1;
            end
            if (q > (64'd1 << 40)) over = 1'b1;
        end
        if (!over && r >= d - r) q = q + 1;
        n.mag = q;
        if (q == 0) n.neg = 1'b0;
        return n;
    endfunction

    function automatic longint atan_of_step(input int k);
        longint tab[11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
        if (k <= 10) return tab[k];
        return (longint'(1) << (ANGLE_FRAC - k)) - 1;
    endfunction

    function automatic t_out_item predict_result(input t_in_item it);
        longint      ar, ai, br, bi, x, y, z, dx, dy;
        t_signmag    vr, vi;
        logic [63:0] d, rem, root, bitv;
        bit          sat;
        t_out_item   o;
        ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
        vr = sm_of(0); vi = sm_of(0);
        sat = 1'b0;
        o = '0;
        case (it.cmd)
            CMD_ADD: begin
                vr = sm_of(ar + br);
                vi = sm_of(ai + bi);
            end
            CMD_SUB: begin
                vr = sm_of(ar - br);
                vi = sm_of(ai - bi);
            end
            CMD_MUL: begin
                vr = sm_sum(sm_mul(ar, br), sm_flip(sm_mul(ai, bi)));
                vi = sm_sum(sm_mul(ar, bi), sm_mul(ai, br));
                vr.mag = round_drop(vr.mag, FRAC_BITS);
                vi.mag = round_drop(vi.mag, FRAC_BITS);
                if (vr.mag == 0) vr.neg = 1'b0;
                if (vi.mag == 0) vi.neg = 1'b0;
            end
            CMD_DIV: begin
                d = sm_mul(br, br).mag + sm_mul(bi, bi).mag;
                if (d == 0) begin
                    o.div_zero = 1'b1;
                end else begin
                    vr = quotient(sm_sum(sm_mul(ar, br), sm_mul(ai, bi)), d);
                    vi = quotient(sm_sum(sm_mul(ai, br), sm_flip(sm_mul(ar, bi))), d);
                end
            end
            CMD_MAG: begin
                rem = sm_mul(ar, ar).mag + sm_mul(ai, ai).mag;
                root = 0;
                bitv = 64'd1 << 62;
                while (bitv > rem) bitv = bitv >> 2;
                while (bitv != 0) begin
                    if (rem >= root + bitv) begin
                        rem = rem - (root + bitv);
                        root = (root >> 1) + bitv;
                    end else begin
                        root = root >> 1;
                    end
                    bitv = bitv >> 2;
                end
                if (rem > root) root = root + 1;
                vr.mag = root;
                vr.neg = 1'b0;
            end
            CMD_ANGLE: begin
                if (ar != 0 || ai != 0) begin
                    x = ar <<< CORDIC_PRESHIFT;
                    y = ai <<< CORDIC_PRESHIFT;
                    z = 0;
                    // turn a left-half operand by pi first
                    if (x < 0) begin
                        z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
                        x = -x;
                        y = -y;
                    end
                    for (int i = 0; i < CORDIC_STEPS; i++) begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (y >= 0) begin
                            x = x + dx; y = y - dy; z = z + atan_of_step(i);
                        end else begin
                            x = x - dx; y = y + dy; z = z - atan_of_step(i);
                        end
                    end
                    vr = sm_of(z);
                    vr.mag = round_drop(vr.mag, ANGLE_FRAC - FRAC_BITS);
                    if (vr.mag == 0) vr.neg = 1'b0;
                end
            end
            default: ;
        endcase
        o.res_re = clip_part(vr, sat);
        o.res_im = clip_part(vi, sat);
        o.saturated = sat;
        return o;
    endfunction

    task automatic send_item(input t_in_item it);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_item <= it;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        pending_results.push_back(predict_result(it));
    endtask

    task automatic send_op(input logic [2:0] c, input logic signed [15:0] xr,
                           input logic signed [15:0] xi, input logic signed [15:0] yr,
                           input logic signed [15:0] yi);
        t_in_item it;
        it.cmd = c; it.a_re = xr; it.a_im = xi; it.b_re = yr; it.b_im = yi;
        send_item(it);
    endtask

    function automatic logic signed [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 15)) - 16'sd8;
            1: return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
            2: return 16'($urandom_range(0, 8191)) - 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))
                                              : 3'($urandom_range(CMD_ADD, CMD_ANGLE));
        it.a_re = rand_operand();
        it.a_im = rand_operand();
        it.b_re = rand_operand();
        it.b_im = rand_operand();
        if ($urandom_range(0, 9) == 0) begin
            it.b_re = '0;
            it.b_im = '0;
        end
        if ($urandom_range(0, 19) == 0) begin
            it.a_re = '0;
            it.a_im = '0;
        end
        return it;
    endfunction

    task automatic test_edge_operands();
        send_op(CMD_ADD, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG);
        send_op(CMD_SUB, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG);
        send_op(CMD_ADD, 16'sd4096, -16'sd4096, 16'sd1, 16'sd2);
        send_op(CMD_SUB, 16'sd100, 16'sd0, 16'sd300, -16'sd7);
        send_op(CMD_MUL, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
        send_op(CMD_MUL, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096);
        send_op(CMD_MUL, -16'sd3, 16'sd5, 16'sd2048, -16'sd2048);
        send_op(CMD_DIV, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096);
        send_op(CMD_DIV, MAX_POS, MAX_NEG, 16'sd1, 16'sd0);
        send_op(CMD_DIV, -16'sd5, 16'sd7, 16'sd3, -16'sd9);
        send_op(CMD_MAG, MAX_NEG, MAX_NEG, 16'sd0, 16'sd0);
        send_op(CMD_MAG, 16'sd3, -16'sd4, 16'sd0, 16'sd0);
        send_op(CMD_ANGLE, -16'sd4096, 16'sd0, 16'sd0, 16'sd0);
        send_op(CMD_ANGLE, -16'sd4096, -16'sd1, 16'sd0, 16'sd0);
        send_op(CMD_ANGLE, 16'sd0, MAX_NEG, 16'sd0, 16'sd0);
        send_op(CMD_ANGLE, MAX_POS, MAX_POS, 16'sd0, 16'sd0);
    endtask

    task automatic test_special_cases();
        send_op(CMD_DIV, 16'sd123, -16'sd456, 16'sd0, 16'sd0);
        send_op(CMD_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_op(CMD_ANGLE, 16'sd0, 16'sd0, MAX_POS, MAX_NEG);
        send_op(CMD_SPARE_LO, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG);
        send_op(CMD_SPARE_HI, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_op(CMD_MAG, 16'sd0, 16'sd0, MAX_NEG, MAX_NEG);
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) send_item(rand_item());
    endtask

    // back-to-back transfers: random push idles and new pop stalls are turned off
    task automatic test_full_rate(input int count);
        idle_en = 1'b0;
        for (int n = 0; n < count; n++) send_item(rand_item());
    endtask

    // result side: random pop stalls, check each transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result re=%0d im=%0d", o_result.res_re, o_result.res_im);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.res_re !== want.res_re) begin
                        $error("res_re expected %0d got %0d", want.res_re, o_result.res_re);
                        failed = 1'b1;
                    end
                    if (o_result.res_im !== want.res_im) begin
                        $error("res_im expected %0d got %0d", want.res_im, o_result.res_im);
                        failed = 1'b1;
                    end
                    if (o_result.div_zero !== want.div_zero) begin
                        $error("div_zero expected %0b got %0b", want.div_zero, o_result.div_zero);
                        failed = 1'b1;
                    end
                    if (o_result.saturated !== want.saturated) begin
                        $error("saturated expected %0b got %0b", want.saturated,
                               o_result.saturated);
                        failed = 1'b1;
                    end
                end
            end
            if (pop_stall > 0) begin
                pop_stall <= pop_stall - 1;
                pop <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                pop_stall <= $urandom_range(0, 17);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_operands();
        test_special_cases();
        test_random_mix(900);
        test_full_rate(200);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("PASS complex_arithmetic_unit");
        end else begin
            $display("FAIL complex_arithmetic_unit");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL complex_arithmetic_unit");
        $finish;
    end

endmodule
